/* hw/rtl/svtd_pkg.sv */
// Shared types, constants and table functions for the sine voice.
`timescale 1ns / 1ps

package svtd_pkg;

    // Default parameter values
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Channel and datapath widths
    localparam int KIND_W    = 2;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 16;
    localparam int S_TDATA_W = 24;
    localparam int AMP_W     = 16;
    localparam int TAIL_W    = 17;
    localparam int MUL_W     = 32;

    // Fixed-point constants
    localparam logic [31:0]       HZ_TO_STEP_RESET = 32'd22906492;
    localparam logic [31:0]       LEVEL_Q16        = 32'd9830;
    localparam logic [31:0]       DECAY_Q16        = 32'd64881;
    localparam logic [TAIL_W-1:0] TAIL_STOP_Q16    = 17'd327;
    localparam logic [TAIL_W-1:0] TAIL_ONE         = 17'h10000;
    localparam logic [63:0]       HALF_PI_Q30      = 64'd1686629713;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK     = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2
    } kind_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_STEP_MUL,
        S_LEVEL_MUL,
        S_LEVEL_DONE,
        S_SINE,
        S_GAIN,
        S_ROUND,
        S_TAIL,
        S_OUT
    } state_t;

    // Note frequencies of the lowest octave in Q.16
    function automatic logic [19:0] semitone_hz(input logic [3:0] idx);
        logic [19:0] hz;
        case (idx)
            4'd0:    hz = 20'd535809;
            4'd1:    hz = 20'd567670;
            4'd2:    hz = 20'd601425;
            4'd3:    hz = 20'd637188;
            4'd4:    hz = 20'd675077;
            4'd5:    hz = 20'd715219;
            4'd6:    hz = 20'd757749;
            4'd7:    hz = 20'd802807;
            4'd8:    hz = 20'd850544;
            4'd9:    hz = 20'd901120;
            4'd10:   hz = 20'd954703;
            4'd11:   hz = 20'd1011473;
            default: hz = 20'd0;
        endcase
        return hz;
    endfunction

    // note / 12 via reciprocal multiply, exact for 7-bit notes
    function automatic logic [3:0] note_octave(input logic [NOTE_W-1:0] note);
        logic [17:0] prod;
        prod = 18'(note) * 18'd171;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] note_semitone(input logic [NOTE_W-1:0] note);
        logic [7:0] twelve_q;
        logic [7:0] diff;
        twelve_q = 8'(note_octave(note)) * 8'd12;
        diff     = 8'(note) - twelve_q;
        return diff[3:0];
    endfunction

    // Quarter-wave sine in Q1.15 by Taylor series; used only at elaboration
    function automatic logic [15:0] quarter_sine(input int unsigned m,
                                                 input int unsigned table_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] prod;
        longint      sum;
        int unsigned quarter;
        x       = '0;
        quarter = 32'd1 << (table_bits - 2);
        x       = ((HALF_PI_Q30 * 64'(m)) + 64'(quarter >> 1)) >> (table_bits - 2);
        x2      = (x * x + (64'd1 << 29)) >> 30;
        term    = x;
        sum     = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            prod = (term * x2) >> 30;
            case (k)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                7:       term = prod / 64'd210;
                default: term = prod / 64'd272;
            endcase
            if ((k % 2) == 1) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        sum = (sum + 16384) >>> 15;
        if (sum > 32767) sum = 32767;
        return 16'(sum);
    endfunction

endpackage

/* hw/rtl/sine_voice_with_tail_decay_top.sv */
// Top level of the single sine voice with exponential release tail.
`timescale 1ns / 1ps

// Single synth voice: phase-accumulator sine oscillator with a decaying tail.
//
// Input channel (s_*): one item per event. s_tuser carries the kind (tick,
// note on, note off); s_tdata carries note number, velocity and tail request.
// Each accepted item gives exactly one result item on the m_* channel: the
// sample (m_tdata), voice-active flag (m_tuser) and note-done flag (m_tlast).
// Configuration: cfg_valid/cfg_ready/cfg_data write hz_to_step; it is read at
// note-on only and must be written while the voice has no item in flight.
//
// Datapath: one shared 32x32 multiplier with a registered product does all the
// arithmetic under a small sequencer, so one item is worked at a time.
// Note off, unused kind and idle tick go from dispatch straight to the output
// state; note on runs the step and level multiplies; a playing tick runs the
// sine, gain and round states, and a tailing tick the tail state after them.
// The block is ready for the next item in the cycle after the result is loaded.
// A tick's multiplier chain is magnitude*level, then *tail gain, then tail decay.
// Reset (aresetn low, synchronous) stops the voice, clears phase, step, level
// and tail, and restores hz_to_step. A stalled receiver holds the result in
// the output register; the block may take one more item and finish it, then
// waits until the output register is free.
module sine_voice_with_tail_decay_top #(
    parameter int PHASE_BITS      = svtd_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = svtd_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = svtd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [6:0] note_number, [22:7] velocity, [23] allow_tail
    input  logic [svtd_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [svtd_pkg::KIND_W-1:0]       s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [SAMPLE_BITS-1:0] sample, zero padded to whole bytes
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,
    // [0] voice_active
    output logic                              m_tuser,
    // note_done
    output logic                              m_tlast,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [31:0]                       cfg_data
);

    localparam int M_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SINE_SIZE  = 1 << SINE_TABLE_BITS;
    localparam int QUARTER    = SINE_SIZE / 4;
    localparam int STEP_SH    = 56 - PHASE_BITS;
    localparam int RND_SH     = 48 - SAMPLE_BITS;
    localparam logic [63:0] STEP_RND   = 64'd1 << (STEP_SH - 1);
    localparam logic [63:0] SAMPLE_RND = 64'd1 << (RND_SH - 1);
    localparam logic [63:0] SAMPLE_LIM = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef logic signed [15:0] sine_tab_t [SINE_SIZE];

    // Full-wave sine table built from the quarter wave by symmetry
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        int unsigned q;
        int unsigned r;
        int unsigned m;
        logic [15:0] v;
        for (int i = 0; i < SINE_SIZE; i++) begin
            q = i / QUARTER;
            r = i % QUARTER;
            m = ((q % 2) == 1) ? (QUARTER - r) : r;
            v = svtd_pkg::quarter_sine(m, SINE_TABLE_BITS);
            tab[i] = (q >= 2) ? -$signed(v) : $signed(v);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    svtd_pkg::state_t state_reg, state_next;

    // captured item
    logic [svtd_pkg::KIND_W-1:0] kind_reg;
    logic [svtd_pkg::NOTE_W-1:0] note_reg;
    logic [svtd_pkg::VEL_W-1:0]  vel_reg;
    logic                        tail_req_reg;

    // voice state
    logic [31:0]                   hz_reg;
    logic [PHASE_BITS-1:0]         phase_reg, phase_next;
    logic [PHASE_BITS-1:0]         step_reg, step_next;
    logic [svtd_pkg::AMP_W-1:0]    amp_reg, amp_next;
    logic [svtd_pkg::TAIL_W-1:0]   tail_reg, tail_next;
    logic                          playing_reg, playing_next;

    // datapath
    logic [svtd_pkg::MUL_W-1:0]    mul_a, mul_b;
    logic [2*svtd_pkg::MUL_W-1:0]  mul_q_reg;
    logic signed [15:0]            rom_q_reg;
    logic                          neg_reg, neg_next;
    logic [SAMPLE_BITS-1:0]        sample_reg, sample_next;
    logic                          done_reg, done_next;

    // output register
    logic                          m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]        m_sample_reg;
    logic                          m_active_reg;
    logic                          m_done_reg;

    logic                          accept;
    logic                          out_load;

    // arithmetic helpers
    logic [3:0]        oct;
    logic [63:0]       step_shift;
    logic [63:0]       step_round;
    logic [31:0]       level_sum;
    logic [33:0]       decay_sum;
    logic [16:0]       decay_val;
    logic [63:0]       mag_round;
    logic [SAMPLE_BITS-1:0] mag_sat;
    logic [15:0]       rom_mag;
    logic [svtd_pkg::TAIL_W-1:0] gain;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign oct        = svtd_pkg::note_octave(note_reg);
    assign step_shift = mul_q_reg << oct;
    assign step_round = (step_shift + STEP_RND) >> STEP_SH;
    assign level_sum  = mul_q_reg[31:0] + 32'd32768;
    assign decay_sum  = 34'(mul_q_reg[32:0]) + 34'd32768;
    assign decay_val  = decay_sum[32:16];
    assign mag_round  = (mul_q_reg + SAMPLE_RND) >> RND_SH;
    assign mag_sat    = (mag_round > SAMPLE_LIM) ? SAMPLE_LIM[SAMPLE_BITS-1:0]
                                                 : mag_round[SAMPLE_BITS-1:0];
    assign rom_mag    = rom_q_reg[15] ? 16'(-rom_q_reg) : 16'(rom_q_reg);
    assign gain       = (tail_reg != '0) ? tail_reg : svtd_pkg::TAIL_ONE;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            svtd_pkg::S_IDLE: begin
                if (accept) state_next = svtd_pkg::S_DISPATCH;
            end
            svtd_pkg::S_DISPATCH: begin
                unique case (kind_reg)
                    svtd_pkg::KIND_NOTE_ON: state_next = svtd_pkg::S_STEP_MUL;
                    svtd_pkg::KIND_TICK:
                        state_next = playing_reg ? svtd_pkg::S_SINE : svtd_pkg::S_OUT;
                    default: state_next = svtd_pkg::S_OUT;
                endcase
            end
            svtd_pkg::S_STEP_MUL:   state_next = svtd_pkg::S_LEVEL_MUL;
            svtd_pkg::S_LEVEL_MUL:  state_next = svtd_pkg::S_LEVEL_DONE;
            svtd_pkg::S_LEVEL_DONE: state_next = svtd_pkg::S_OUT;
            svtd_pkg::S_SINE:       state_next = svtd_pkg::S_GAIN;
            svtd_pkg::S_GAIN:       state_next = svtd_pkg::S_ROUND;
            svtd_pkg::S_ROUND: begin
                state_next = (tail_reg != '0) ? svtd_pkg::S_TAIL : svtd_pkg::S_OUT;
            end
            svtd_pkg::S_TAIL:       state_next = svtd_pkg::S_OUT;
            svtd_pkg::S_OUT: begin
                if (out_load) state_next = svtd_pkg::S_IDLE;
            end
            default:                state_next = svtd_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and shared multiplier operands
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            svtd_pkg::S_IDLE: s_tready = 1'b1;
            svtd_pkg::S_STEP_MUL: begin
                mul_a = 32'(svtd_pkg::semitone_hz(svtd_pkg::note_semitone(note_reg)));
                mul_b = hz_reg;
            end
            svtd_pkg::S_LEVEL_MUL: begin
                mul_a = 32'(vel_reg);
                mul_b = svtd_pkg::LEVEL_Q16;
            end
            svtd_pkg::S_SINE: begin
                mul_a = 32'(rom_mag);
                mul_b = 32'(amp_reg);
            end
            svtd_pkg::S_GAIN: begin
                mul_a = mul_q_reg[31:0];
                mul_b = 32'(gain);
            end
            svtd_pkg::S_ROUND: begin
                mul_a = 32'(tail_reg);
                mul_b = svtd_pkg::DECAY_Q16;
            end
            svtd_pkg::S_OUT: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // Voice state updates
    always_comb begin
        phase_next   = phase_reg;
        step_next    = step_reg;
        amp_next     = amp_reg;
        tail_next    = tail_reg;
        playing_next = playing_reg;
        neg_next     = neg_reg;
        sample_next  = sample_reg;
        done_next    = done_reg;
        case (state_reg)
            svtd_pkg::S_DISPATCH: begin
                sample_next = '0;
                done_next   = 1'b0;
                // note off: start the tail once, or stop at once
                if (kind_reg == svtd_pkg::KIND_NOTE_OFF && playing_reg) begin
                    if (tail_req_reg) begin
                        if (tail_reg == '0) tail_next = svtd_pkg::TAIL_ONE;
                    end else begin
                        playing_next = 1'b0;
                        step_next    = '0;
                        tail_next    = '0;
                        done_next    = 1'b1;
                    end
                end
            end
            svtd_pkg::S_LEVEL_MUL: step_next = step_round[PHASE_BITS-1:0];
            svtd_pkg::S_LEVEL_DONE: begin
                amp_next     = level_sum[31:16];
                phase_next   = '0;
                tail_next    = '0;
                playing_next = 1'b1;
            end
            svtd_pkg::S_SINE: neg_next = rom_q_reg[15];
            svtd_pkg::S_GAIN: phase_next = phase_reg + step_reg;
            svtd_pkg::S_ROUND: sample_next = neg_reg ? SAMPLE_BITS'(-mag_sat) : mag_sat;
            svtd_pkg::S_TAIL: begin
                tail_next = decay_val;
                if (decay_val <= svtd_pkg::TAIL_STOP_Q16) begin
                    playing_next = 1'b0;
                    step_next    = '0;
                    tail_next    = '0;
                    done_next    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control and voice state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= svtd_pkg::S_IDLE;
            hz_reg       <= svtd_pkg::HZ_TO_STEP_RESET;
            phase_reg    <= '0;
            step_reg     <= '0;
            amp_reg      <= '0;
            tail_reg     <= '0;
            playing_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            amp_reg     <= amp_next;
            tail_reg    <= tail_next;
            playing_reg <= playing_next;
            if (cfg_valid && cfg_ready) hz_reg <= cfg_data;
            if (out_load)      m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers: item capture, shared product, sine table read, result
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg     <= s_tuser;
            note_reg     <= s_tdata[6:0];
            vel_reg      <= s_tdata[22:7];
            tail_req_reg <= s_tdata[23];
        end
        mul_q_reg  <= mul_a * mul_b;
        rom_q_reg  <= SINE_TAB[phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]];
        neg_reg    <= neg_next;
        sample_reg <= sample_next;
        done_reg   <= done_next;
        if (out_load) begin
            m_sample_reg <= sample_reg;
            m_active_reg <= playing_reg;
            m_done_reg   <= done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_sample_reg);
    assign m_tuser  = m_active_reg;
    assign m_tlast  = m_done_reg;

    // Between items a stopped voice carries no tail and no step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == svtd_pkg::S_IDLE && !playing_reg) |->
            (tail_reg == '0 && step_reg == '0))
        else $error("idle voice holds tail or step");

    // A running tail never rests at or below the stop level between items
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == svtd_pkg::S_IDLE && tail_reg != '0) |->
            (tail_reg > svtd_pkg::TAIL_STOP_Q16))
        else $error("tail rests below stop level");

    // A finished note is never reported as still active
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tlast && m_tuser))
        else $error("note done while voice active");

    // After an item is taken the block stays busy until its result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("item taken while busy");

    // Loading the output register always presents a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

/* verif/tb_sine_voice_with_tail_decay_top.sv */
// Self-checking testbench for the sine voice with exponential release tail.
`timescale 1ns / 1ps

module tb_sine_voice_with_tail_decay_top;

    localparam int          CLK_HALF     = 5;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SETTLE       = 20;
    localparam int          PHASE_ITEMS  = 60;
    localparam int          DECAY_TICKS  = 560;
    localparam logic [1:0]  KIND_SPARE   = 2'd3;
    localparam logic [31:0] RATE_DEFAULT = 32'd22906492;

    // One expected result item
    typedef struct packed {
        logic [15:0] sample;
        logic        active;
        logic        done;
    } voice_result_t;

    // Tracks the voice state, predicts each result and matches what comes out
    class voice_score;
        logic signed [15:0] sine_q15 [1024];
        int unsigned        semitone_q16 [12];
        logic [31:0]        step_rate;
        logic [31:0]        phase;
        logic [31:0]        phase_step;
        logic [15:0]        level;
        logic [16:0]        tail;
        bit                 playing;
        voice_result_t      due_q [$];
        int                 errors;

        function new();
            int unsigned quad;
            int unsigned rem;
            int          v;
            semitone_q16 = '{535809, 567670, 601425, 637188, 675077, 715219,
                             757749, 802807, 850544, 901120, 954703, 1011473};
            for (int i = 0; i < 1024; i++) begin
                quad = i / 256;
                rem  = i % 256;
                v    = quarter_wave(quad[0] ? 256 - rem : rem);
                sine_q15[i] = quad[1] ? 16'(-v) : 16'(v);
            end
            step_rate  = RATE_DEFAULT;
            phase      = '0;
            phase_step = '0;
            level      = '0;
            tail       = '0;
            playing    = 1'b0;
            errors     = 0;
        endfunction

        // Quarter-wave sine, Taylor series on a Q30 angle, result in Q1.15
        function int quarter_wave(int unsigned m);
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          acc;
            x    = (64'd1686629713 * 64'(m) + 64'd128) >> 8;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
                if (k % 2 == 1) acc = acc - longint'(term);
                else            acc = acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            acc = (acc + 16384) >>> 15;
            if (acc > 32767) acc = 32767;
            return int'(acc);
        endfunction

        function void set_step_rate(logic [31:0] rate);
            step_rate = rate;
        endfunction

        function void silence();
            playing    = 1'b0;
            phase_step = '0;
            tail       = '0;
        endfunction

        // Advance the voice by one accepted input item and queue its result
        function void note_event(logic [1:0] kind, logic [6:0] note,
                                 logic [15:0] vel, logic allow);
            voice_result_t   r;
            longint unsigned prod;
            longint unsigned mag;
            longint unsigned gain;
            int              s;
            r = '0;
            case (kind)
                svtd_pkg::KIND_NOTE_ON: begin
                    prod       = 64'(semitone_q16[note % 12]) * 64'(step_rate);
                    prod       = prod << (note / 12);
                    phase_step = 32'((prod + (64'd1 << 23)) >> 24);
                    phase      = '0;
                    tail       = '0;
                    level      = 16'((64'(vel) * 64'd9830 + 64'd32768) >> 16);
                    playing    = 1'b1;
                end
                svtd_pkg::KIND_NOTE_OFF: begin
                    if (playing) begin
                        if (allow) begin
                            if (tail == '0) tail = 17'h10000;
                        end else begin
                            silence();
                            r.done = 1'b1;
                        end
                    end
                end
                svtd_pkg::KIND_TICK: begin
                    if (playing) begin
                        s    = sine_q15[phase[31:22]];
                        mag  = 64'(s < 0 ? -s : s);
                        gain = (tail != '0) ? 64'(tail) : 64'd65536;
                        mag  = (mag * 64'(level) * gain + (64'd1 << 31)) >> 32;
                        if (mag > 64'd32767) mag = 64'd32767;
                        r.sample = (s < 0) ? 16'(-longint'(mag)) : 16'(mag);
                        phase    = phase + phase_step;
                        if (tail != '0) begin
                            tail = 17'((64'(tail) * 64'd64881 + 64'd32768) >> 16);
                            if (tail <= 17'd327) begin
                                silence();
                                r.done = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.active = playing;
            due_q.push_back(r);
        endfunction

        function void check_sample(logic [15:0] sample, logic active, logic done);
            voice_result_t w;
            if (due_q.size() == 0) begin
                $display("%0t: result with nothing expected: sample %0d active %0b done %0b",
                         $time, $signed(sample), active, done);
                errors++;
                return;
            end
            w = due_q.pop_front();
            if (sample !== w.sample) begin
                $display("%0t: sample expected %0d actual %0d",
                         $time, $signed(w.sample), $signed(sample));
                errors++;
            end
            if (active !== w.active) begin
                $display("%0t: voice_active expected %0b actual %0b", $time, w.active, active);
                errors++;
            end
            if (done !== w.done) begin
                $display("%0t: note_done expected %0b actual %0b", $time, w.done, done);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [6:0] note_number, [22:7] velocity, [23] allow_tail
    logic [23:0] s_tdata;
    // [1:0] kind
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // [15:0] sample
    logic [15:0] m_tdata;
    // [0] voice_active
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    voice_score score;
    bit         idle_on;
    bit         hold_request;
    int         sent_items;
    int         cycle_count;

    sine_voice_with_tail_decay_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog: end the run if the block stops making progress
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: check every item taken, then pick m_tready for the next edge.
    // A hold request drops ready for a long stretch so the block backs up.
    initial begin
        int stall_left;
        int hold_left;
        bit ready_next;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                score.check_sample(m_tdata, m_tuser, m_tlast);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 8);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    // Offer one item, possibly after a short gap, and hold it until taken
    task automatic send_item(input logic [1:0] kind, input logic [6:0] note,
                             input logic [15:0] vel, input logic allow);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {allow, vel, note};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        score.note_event(kind, note, vel, allow);
        sent_items++;
    endtask

    task automatic send_tick();
        send_item(svtd_pkg::KIND_TICK, 7'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_tick();
    endtask

    task automatic send_note_on(input logic [6:0] note, input logic [15:0] vel);
        send_item(svtd_pkg::KIND_NOTE_ON, note, vel, 1'($urandom));
    endtask

    task automatic send_note_off(input logic allow);
        send_item(svtd_pkg::KIND_NOTE_OFF, 7'($urandom), 16'($urandom), allow);
    endtask

    // Stop offering and hold until every outstanding result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (score.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic write_rate(input logic [31:0] rate);
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        score.set_step_rate(rate);
    endtask

    // Note played, released with a tail, ticked until the tail dies out
    task automatic full_decay();
        send_note_on(7'($urandom_range(40, 90)), 16'($urandom_range(30000, 65535)));
        send_ticks(10);
        send_note_off(1'b1);
        send_ticks(DECAY_TICKS);
    endtask

    // One random phrase: mostly well-formed notes, some noise
    task automatic random_phrase();
        int pick;
        int n;
        logic [6:0]  note;
        logic [15:0] vel;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            // noise: any kind, any fields
            repeat ($urandom_range(1, 5))
                send_item(2'($urandom), 7'($urandom), 16'($urandom), 1'($urandom));
            return;
        end
        case ($urandom_range(0, 7))
            0:       note = 7'd0;
            1:       note = 7'd127;
            default: note = 7'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       vel = 16'd0;
            1:       vel = 16'hFFFF;
            default: vel = 16'($urandom);
        endcase
        send_note_on(note, vel);
        n = $urandom_range(1, 40);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0)
                send_item(KIND_SPARE, 7'($urandom), 16'($urandom), 1'($urandom));
            else
                send_tick();
        end
        if (pick == 1) return;    // leave the note ringing into the next phrase
        send_note_off($urandom_range(0, 3) != 0);
        n = $urandom_range(0, 60);
        repeat (n) begin
            if ($urandom_range(0, 24) == 0) send_note_off(1'($urandom));
            else                            send_tick();
        end
    endtask

    task automatic random_items(input int count);
        int stop_at;
        stop_at = sent_items + count;
        while (sent_items < stop_at) begin
            if (!hold_request) idle_on = ($urandom_range(0, 3) != 0);
            random_phrase();
        end
    endtask

    initial begin
        logic [31:0] rates [4];
        score        = new();
        idle_on      = 1'b1;
        hold_request = 1'b0;
        sent_items   = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= svtd_pkg::KIND_TICK;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle behavior, extremes, tail handling, restarts
        send_tick();                                // tick while idle
        send_note_off(1'b1);                        // note off while idle
        send_note_off(1'b0);
        send_item(KIND_SPARE, 7'h7F, 16'hFFFF, 1'b1);
        send_note_on(7'd127, 16'hFFFF);
        send_ticks(3);
        send_note_off(1'b1);                        // start the tail
        send_tick();
        send_note_off(1'b1);                        // running tail must not restart
        send_ticks(2);
        send_note_on(7'd0, 16'd0);                  // restart while playing, silent level
        send_tick();
        send_note_off(1'b0);                        // hard stop
        send_tick();
        send_note_on(7'd69, 16'h8000);
        send_ticks(2);
        send_item(KIND_SPARE, 7'd0, 16'd0, 1'b0);
        send_note_on(7'd60, 16'd1);
        send_tick();
        send_note_off(1'b0);

        // Phase with the reset step rate, including one tail run to its end
        full_decay();
        random_items(PHASE_ITEMS);

        rates[0] = 32'hFFFF_FFFF;
        rates[1] = 32'h0000_0000;
        rates[2] = $urandom;
        rates[3] = RATE_DEFAULT;
        for (int p = 0; p < 4; p++) begin
            drain();
            write_rate(rates[p]);
            if (p == 0) begin
                // back up the block behind a long receiver stall
                idle_on      = 1'b0;
                hold_request = 1'b1;
            end
            if (p == 3) begin
                // final stretch runs at full rate on both sides
                idle_on = 1'b0;
                repeat (3) random_phrase();
            end else begin
                random_items(PHASE_ITEMS / 2);
                if (p == 1) drain();
                random_items(PHASE_ITEMS / 2);
            end
        end

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (score.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
